// ----- sv/drt_pkg.sv -----
// Shared types, constants and compact-target helpers for the difficulty retarget block.
package drt_pkg;

  localparam int TGT_W      = 256;
  localparam int NBYTE      = TGT_W / 8;
  localparam int SB_W       = $clog2(NBYTE);
  localparam int DIV_STEPS  = 8;
  localparam int DIV_STAGES = TGT_W / DIV_STEPS;

  localparam int H_W        = 31;
  localparam int CB_W       = 32;
  localparam int TIME_W     = 32;
  localparam int SPAN_W     = 24;
  localparam int TS_W       = SPAN_W + 2;
  localparam int MANT_W     = 23;
  localparam int PROD_W     = MANT_W + TS_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_ERAS   = 5;

  // Reciprocal constants for the exact floors of the windowed clamp bounds.
  localparam int RECIP_K = 37;
  localparam int RECIP_W = 30;
  localparam int NUM_W   = SPAN_W + 3;
  localparam int RPROD_W = NUM_W + RECIP_W;
  localparam int QUO_W   = RPROD_W - RECIP_K;

  localparam int LO_D1 = 1007;
  localparam int LO_D2 = 507;
  localparam int LO_D3 = 257;
  localparam int HI_D2 = 500;
  localparam int HI_D3 = 250;

  localparam logic [RECIP_W-1:0] M_LO1 =
    RECIP_W'(((64'd1 << RECIP_K) + 64'(LO_D1) - 64'd1) / 64'(LO_D1));
  localparam logic [RECIP_W-1:0] M_LO2 =
    RECIP_W'(((64'd1 << RECIP_K) + 64'(LO_D2) - 64'd1) / 64'(LO_D2));
  localparam logic [RECIP_W-1:0] M_LO3 =
    RECIP_W'(((64'd1 << RECIP_K) + 64'(LO_D3) - 64'd1) / 64'(LO_D3));
  localparam logic [RECIP_W-1:0] M_HI2 =
    RECIP_W'(((64'd1 << RECIP_K) + 64'(HI_D2) - 64'd1) / 64'(HI_D2));
  localparam logic [RECIP_W-1:0] M_HI3 =
    RECIP_W'(((64'd1 << RECIP_K) + 64'(HI_D3) - 64'd1) / 64'(HI_D3));

  localparam logic [TS_W-1:0]   ERA4_LO  = TS_W'(59);
  localparam logic [TS_W-1:0]   ERA4_HI  = TS_W'(61);
  localparam logic [SPAN_W-1:0] ERA4_DIV = SPAN_W'(60);
  localparam logic [TS_W-1:0]   ERA5_LO  = TS_W'(37);
  localparam logic [TS_W-1:0]   ERA5_HI  = TS_W'(39);
  localparam logic [SPAN_W-1:0] ERA5_DIV = SPAN_W'(38);

  localparam logic [SPAN_W-1:0] LEGACY_RST = SPAN_W'(1209600);
  localparam logic [SPAN_W-1:0] WINDOW_RST = SPAN_W'(60);
  localparam logic [CB_W-1:0]   LIMIT_RST  = 32'h1d00ffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERA1   = 4'd0,
    CFG_ERA2   = 4'd1,
    CFG_ERA3   = 4'd2,
    CFG_ERA4   = 4'd3,
    CFG_ERA5   = 4'd4,
    CFG_LEGACY = 4'd5,
    CFG_WINDOW = 4'd6,
    CFG_LIMIT  = 4'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ERA_LEGACY, ERA_1, ERA_2, ERA_3, ERA_4, ERA_5
  } era_t;

  typedef struct packed {
    logic [NUM_ERAS-1:0][H_W-1:0] era_start;
    logic [SPAN_W-1:0]            legacy_span;
    logic [SPAN_W-1:0]            window_span;
  } cfg_t;

  typedef struct packed {
    logic [MANT_W-1:0] mant;
    logic [SB_W-1:0]   sbyte;
  } csplit_t;

  typedef struct packed {
    logic [MANT_W-1:0] mant;
    logic [SB_W-1:0]   sbyte;
    logic [TS_W-1:0]   ts;
    logic [SPAN_W-1:0] dvsr;
  } front_t;

  typedef struct packed {
    logic [TGT_W-1:0]  xq;
    logic [SPAN_W-1:0] rem;
    logic [SPAN_W-1:0] dvsr;
  } div_t;

  // Splits a compact value into an effective mantissa and a byte shift. Mantissa
  // bytes that fall below bit zero are dropped here, and a shift that puts the
  // whole value above the target width yields a zero mantissa.
  function automatic csplit_t compact_split(input logic [CB_W-1:0] bits);
    csplit_t           s;
    logic [7:0]        size;
    logic [MANT_W-1:0] m;
    size    = bits[31:24];
    m       = bits[MANT_W-1:0];
    s.sbyte = '0;
    if (size == 8'd0) begin
      s.mant = '0;
    end else if (size == 8'd1) begin
      s.mant = m >> 16;
    end else if (size == 8'd2) begin
      s.mant = m >> 8;
    end else if (size > 8'(NBYTE + 2)) begin
      s.mant = '0;
    end else begin
      s.mant  = m;
      s.sbyte = SB_W'(size - 8'd3);
    end
    return s;
  endfunction

endpackage

// ----- sv/drt_in_if.sv -----
// Input channel: valid/ready handshake carrying one retarget request.
interface drt_in_if;
  logic                      valid;
  logic                      ready;
  logic [drt_pkg::H_W-1:0]    next_height;
  logic [drt_pkg::CB_W-1:0]   last_bits;
  logic [drt_pkg::TIME_W-1:0] last_time;
  logic [drt_pkg::TIME_W-1:0] first_time;

  modport source (output valid, next_height, last_bits, last_time, first_time,
                  input ready);
  modport sink (input valid, next_height, last_bits, last_time, first_time,
                output ready);
endinterface

// ----- sv/drt_out_if.sv -----
// Output channel: valid/ready handshake carrying one compact target.
interface drt_out_if;
  logic                    valid;
  logic                    ready;
  logic [drt_pkg::CB_W-1:0] new_bits;

  modport source (output valid, new_bits, input ready);
  modport sink (input valid, new_bits, output ready);
endinterface

// ----- sv/difficulty_retarget.sv -----
// Top level of the compact-target difficulty retarget pipeline.
//
// Each transaction on in_ch carries the next block height, the last block's
// compact target and the two window timestamps; one transaction on out_ch
// returns the new compact target, in the order the requests were accepted.
// The configuration port takes a write on every edge with cfg_we high;
// cfg_index selects the register and indexes past the list are ignored.
// Configuration must only change while the pipeline is empty.
// From acceptance to out_ch.valid the pipeline runs through three front-end
// stages (era, bound multiply, clamp), two scaling stages, 32 division stages
// that retire eight quotient bits each, and two encode stages.
// Throughput is one transaction per cycle while out_ch is ready; every stage
// carries its own valid bit and loads whenever it is empty or its successor
// loads, so a stalled out_ch fills the bubbles before in_ch.ready drops.
// Synchronous reset empties the pipeline and loads the register defaults.
module difficulty_retarget (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [drt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drt_pkg::CFG_DATA_W-1:0] cfg_data,
  drt_in_if.sink                         in_ch,
  drt_out_if.source                      out_ch
);
  import drt_pkg::*;

  cfg_t            cfg;
  logic [CB_W-1:0] limit_compact;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.era_start   <= '0;
      cfg.legacy_span <= LEGACY_RST;
      cfg.window_span <= WINDOW_RST;
      limit_compact   <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ERA1:   cfg.era_start[0] <= cfg_data[H_W-1:0];
        CFG_ERA2:   cfg.era_start[1] <= cfg_data[H_W-1:0];
        CFG_ERA3:   cfg.era_start[2] <= cfg_data[H_W-1:0];
        CFG_ERA4:   cfg.era_start[3] <= cfg_data[H_W-1:0];
        CFG_ERA5:   cfg.era_start[4] <= cfg_data[H_W-1:0];
        CFG_LEGACY: cfg.legacy_span  <= cfg_data[SPAN_W-1:0];
        CFG_WINDOW: cfg.window_span  <= cfg_data[SPAN_W-1:0];
        CFG_LIMIT:  limit_compact    <= cfg_data[CB_W-1:0];
        default: ;
      endcase
    end
  end

  logic   f_valid, f_ready;
  front_t f_data;
  logic   d_valid [DIV_STAGES+1];
  logic   d_ready [DIV_STAGES+1];
  div_t   d_data  [DIV_STAGES+1];

  drt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .up_valid    (in_ch.valid),
    .up_ready    (in_ch.ready),
    .next_height (in_ch.next_height),
    .last_bits   (in_ch.last_bits),
    .last_time   (in_ch.last_time),
    .first_time  (in_ch.first_time),
    .dn_valid    (f_valid),
    .dn_ready    (f_ready),
    .dn_data     (f_data)
  );

  drt_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_data  (f_data),
    .dn_valid (d_valid[0]),
    .dn_ready (d_ready[0]),
    .dn_data  (d_data[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    drt_div_stage u_div (
      .clk      (clk),
      .rst      (rst),
      .up_valid (d_valid[g]),
      .up_ready (d_ready[g]),
      .up_data  (d_data[g]),
      .dn_valid (d_valid[g+1]),
      .dn_ready (d_ready[g+1]),
      .dn_data  (d_data[g+1])
    );
  end

  drt_encode u_encode (
    .clk           (clk),
    .rst           (rst),
    .limit_compact (limit_compact),
    .up_valid      (d_valid[DIV_STAGES]),
    .up_ready      (d_ready[DIV_STAGES]),
    .up_data       (d_data[DIV_STAGES]),
    .dn_valid      (out_ch.valid),
    .dn_ready      (out_ch.ready),
    .new_bits      (out_ch.new_bits)
  );

  // Input backpressure can only come from a pipeline that is full to the end.
  a_full_before_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled while the output register is empty");

  a_scale_full_before_stall: assert property (@(posedge clk) disable iff (rst)
    !f_ready |-> d_valid[0])
    else $error("front end stalled while the scaling output is empty");

endmodule

// ----- sv/drt_front.sv -----
// Front end: era selection, clamp bounds and timespan clamp, compact split.
module drt_front (
  input  logic                       clk,
  input  logic                       rst,
  input  drt_pkg::cfg_t              cfg,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [drt_pkg::H_W-1:0]    next_height,
  input  logic [drt_pkg::CB_W-1:0]   last_bits,
  input  logic [drt_pkg::TIME_W-1:0] last_time,
  input  logic [drt_pkg::TIME_W-1:0] first_time,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output drt_pkg::front_t            dn_data
);
  import drt_pkg::*;

  logic v1, v2;
  logic rdy1, rdy2, rdy3;

  era_t                era_in, era1, era2;
  logic signed [TIME_W:0] ts1, ts2;
  logic [CB_W-1:0]     bits1, bits2;

  logic [NUM_W-1:0]    wn7, lo_num;
  logic [RECIP_W-1:0]  m_lo, m_hi;
  logic [RPROD_W-1:0]  lo_prod, hi_prod;
  logic [QUO_W-1:0]    qlo2, qhi2;

  logic [TS_W-1:0]     lo, hi;
  logic [SPAN_W-1:0]   dv;
  logic signed [TIME_W:0] lo_s, hi_s, tsc;
  csplit_t             cs;

  assign rdy1     = !v1 || rdy2;
  assign rdy2     = !v2 || rdy3;
  assign rdy3     = !dn_valid || dn_ready;
  assign up_ready = rdy1;

  always_comb begin
    if (next_height < cfg.era_start[0]) begin
      era_in = ERA_LEGACY;
    end else if (next_height < cfg.era_start[1]) begin
      era_in = ERA_1;
    end else if (next_height < cfg.era_start[2]) begin
      era_in = ERA_2;
    end else if (next_height < cfg.era_start[3]) begin
      era_in = ERA_3;
    end else if (next_height < cfg.era_start[4]) begin
      era_in = ERA_4;
    end else begin
      era_in = ERA_5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= up_valid;
    end
    if (rdy1) begin
      era1  <= era_in;
      ts1   <= $signed({1'b0, last_time}) - $signed({1'b0, first_time});
      bits1 <= last_bits;
    end
  end

  // The windowed bounds need floor(7*W/d) and ceil(7*W/d); both come from a
  // multiply by a rounded-up reciprocal that is exact over the whole input range.
  always_comb begin
    wn7 = NUM_W'({cfg.window_span, 3'b000}) - NUM_W'(cfg.window_span);
    case (era1)
      ERA_1: begin
        lo_num = wn7 + NUM_W'(LO_D1 - 1);
        m_lo   = M_LO1;
      end
      ERA_2: begin
        lo_num = wn7 + NUM_W'(LO_D2 - 1);
        m_lo   = M_LO2;
      end
      default: begin
        lo_num = wn7 + NUM_W'(LO_D3 - 1);
        m_lo   = M_LO3;
      end
    endcase
    m_hi    = (era1 == ERA_2) ? M_HI2 : M_HI3;
    lo_prod = RPROD_W'(lo_num) * RPROD_W'(m_lo);
    hi_prod = RPROD_W'(wn7) * RPROD_W'(m_hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      era2  <= era1;
      ts2   <= ts1;
      bits2 <= bits1;
      qlo2  <= lo_prod[RECIP_K +: QUO_W];
      qhi2  <= hi_prod[RECIP_K +: QUO_W];
    end
  end

  always_comb begin
    case (era2) inside
      ERA_LEGACY: begin
        lo = TS_W'(cfg.legacy_span >> 2);
        hi = {cfg.legacy_span, 2'b00};
        dv = cfg.legacy_span;
      end
      ERA_1: begin
        lo = TS_W'(cfg.window_span) - TS_W'(qlo2);
        hi = TS_W'(cfg.window_span) + TS_W'(cfg.window_span >> 1);
        dv = cfg.window_span;
      end
      ERA_2, ERA_3: begin
        lo = TS_W'(cfg.window_span) - TS_W'(qlo2);
        hi = TS_W'(cfg.window_span) + TS_W'(qhi2);
        dv = cfg.window_span;
      end
      ERA_4: begin
        lo = ERA4_LO;
        hi = ERA4_HI;
        dv = ERA4_DIV;
      end
      default: begin
        lo = ERA5_LO;
        hi = ERA5_HI;
        dv = ERA5_DIV;
      end
    endcase
    lo_s = $signed({(TIME_W + 1 - TS_W)'(0), lo});
    hi_s = $signed({(TIME_W + 1 - TS_W)'(0), hi});
    tsc  = ts2;
    if (tsc < lo_s) begin
      tsc = lo_s;
    end
    if (tsc > hi_s) begin
      tsc = hi_s;
    end
    cs = compact_split(bits2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (rdy3) begin
      dn_valid <= v2;
    end
    if (rdy3) begin
      dn_data.mant  <= cs.mant;
      dn_data.sbyte <= cs.sbyte;
      dn_data.ts    <= TS_W'(tsc);
      dn_data.dvsr  <= dv;
    end
  end

endmodule

// ----- sv/drt_scale.sv -----
// Target scaling: mantissa times clamped timespan, then byte placement to full width.
module drt_scale (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  drt_pkg::front_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output drt_pkg::div_t   dn_data
);
  import drt_pkg::*;

  logic              v1;
  logic              rdy1, rdy2;
  logic [PROD_W-1:0] prod1;
  logic [SB_W-1:0]   sb1;
  logic [SPAN_W-1:0] dv1;

  assign rdy1     = !v1 || rdy2;
  assign rdy2     = !dn_valid || dn_ready;
  assign up_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= up_valid;
    end
    if (rdy1) begin
      prod1 <= PROD_W'(up_data.mant) * PROD_W'(up_data.ts);
      sb1   <= up_data.sbyte;
      dv1   <= up_data.dvsr;
    end
  end

  // Bits shifted past the top are dropped: the product is taken modulo 2^TGT_W.
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (rdy2) begin
      dn_valid <= v1;
    end
    if (rdy2) begin
      dn_data.xq   <= TGT_W'(prod1) << {sb1, 3'b000};
      dn_data.rem  <= '0;
      dn_data.dvsr <= dv1;
    end
  end

endmodule

// ----- sv/drt_div_stage.sv -----
// One restoring-division stage: retires DIV_STEPS quotient bits per transaction.
module drt_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  drt_pkg::div_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output drt_pkg::div_t dn_data
);
  import drt_pkg::*;

  logic              rdy;
  logic [TGT_W-1:0]  x;
  logic [SPAN_W-1:0] r;
  logic [SPAN_W:0]   tmp;
  logic              ge;

  assign rdy      = !dn_valid || dn_ready;
  assign up_ready = rdy;

  // Dividend bits leave at the top while quotient bits enter at the bottom.
  // A zero divisor makes every step succeed, so the quotient comes out all ones.
  always_comb begin
    x = up_data.xq;
    r = up_data.rem;
    for (int i = 0; i < DIV_STEPS; i++) begin
      tmp = {r, x[TGT_W-1]};
      ge  = tmp >= {1'b0, up_data.dvsr};
      x   = {x[TGT_W-2:0], ge};
      r   = ge ? SPAN_W'(tmp - {1'b0, up_data.dvsr}) : SPAN_W'(tmp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (rdy) begin
      dn_valid <= up_valid;
    end
    if (rdy) begin
      dn_data.xq   <= x;
      dn_data.rem  <= r;
      dn_data.dvsr <= up_data.dvsr;
    end
  end

  a_rem_below_dvsr: assert property (@(posedge clk) disable iff (rst)
    dn_valid && (dn_data.dvsr != '0) |-> dn_data.rem < dn_data.dvsr)
    else $error("division remainder not below divisor");

endmodule

// ----- sv/drt_encode.sv -----
// Back end: saturation at the decoded limit and compact re-encoding.
module drt_encode (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [drt_pkg::CB_W-1:0] limit_compact,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  drt_pkg::div_t            up_data,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output logic [drt_pkg::CB_W-1:0] new_bits
);
  import drt_pkg::*;

  logic                 v1;
  logic                 rdy1, rdy2;
  logic [TGT_W-1:0]     lim, val1;
  csplit_t              ls;
  logic [SB_W:0]        sz;
  logic [TGT_W+23:0]    wide;
  logic [23:0]          mant24;
  logic [7:0]           size_out;

  assign rdy1     = !v1 || rdy2;
  assign rdy2     = !dn_valid || dn_ready;
  assign up_ready = rdy1;
  assign ls       = compact_split(limit_compact);

  // The user must change the limit only while the pipeline is empty; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    lim <= TGT_W'(ls.mant) << {ls.sbyte, 3'b000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= up_valid;
    end
    if (rdy1) begin
      val1 <= (up_data.xq > lim) ? lim : up_data.xq;
    end
  end

  always_comb begin
    sz = '0;
    for (int k = 0; k < NBYTE; k++) begin
      if (val1[8*k +: 8] != 8'd0) begin
        sz = (SB_W + 1)'(k + 1);
      end
    end
    wide     = {val1, 24'd0};
    mant24   = wide[{sz, 3'b000} +: 24];
    size_out = 8'(sz);
    // A mantissa with its top bit set would read as negative; move up a byte.
    if (mant24[23]) begin
      mant24   = mant24 >> 8;
      size_out = size_out + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (rdy2) begin
      dn_valid <= v1;
    end
    if (rdy2) begin
      new_bits <= {size_out, 1'b0, mant24[22:0]};
    end
  end

  a_no_sign_bit: assert property (@(posedge clk) disable iff (rst)
    dn_valid |-> !new_bits[23])
    else $error("encoded target has the sign bit set");

endmodule

// ----- dv/drt_checker.sv -----
// Checker for the difficulty retarget block: predicts each new compact target and compares.
module drt_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [drt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drt_pkg::CFG_DATA_W-1:0] cfg_data,
  drt_in_if.sink                         in_mon,
  drt_out_if.sink                        out_mon,
  output int                             fail_count,
  output int                             pending
);
  import drt_pkg::*;

  logic [30:0] era_start [5];
  logic [23:0] legacy_span;
  logic [23:0] window_span;
  logic [31:0] limit_bits;
  logic [31:0] target_q [$];

  assign pending = target_q.size();

  // Compact form to a full target; bytes outside the target width are dropped.
  function automatic logic [255:0] expand_compact(logic [31:0] bits);
    logic [255:0] x;
    int           sz;
    x  = '0;
    sz = bits[31:24];
    for (int j = 0; j < 3; j++) begin
      if (sz - 3 + j >= 0 && sz - 3 + j < 32) begin
        x[(sz - 3 + j) * 8 +: 8] = 8'((bits[22:0] >> (8 * j)) & 23'hff);
      end
    end
    return x;
  endfunction

  function automatic logic [31:0] pack_compact(logic [255:0] x);
    int          sz;
    logic [31:0] m;
    sz = 0;
    for (int k = 31; k >= 0; k--) begin
      if (x[k * 8 +: 8] != 0) begin
        sz = k + 1;
        break;
      end
    end
    m = 0;
    for (int j = 1; j <= 3; j++) begin
      if (sz - j >= 0) m = m | (32'(x[(sz - j) * 8 +: 8]) << (8 * (3 - j)));
    end
    if (m[23]) begin
      m = m >> 8;
      sz++;
    end
    return {8'(sz), 1'b0, m[22:0]};
  endfunction

  function automatic logic [31:0] retarget(logic [30:0] h, logic [31:0] bits,
                                           logic [31:0] tl, logic [31:0] tf);
    longint       ts, lo, hi, dv, t, w;
    logic [287:0] prod;
    logic [255:0] val, lim;
    t  = legacy_span;
    w  = window_span;
    ts = longint'(tl) - longint'(tf);
    if (h < era_start[0]) begin
      lo = t / 4; hi = t * 4; dv = t;
    end else if (h < era_start[1]) begin
      lo = w * 1000 / 1007; hi = w * 3 / 2; dv = w;
    end else if (h < era_start[2]) begin
      lo = w * 1000 / 1014; hi = w * 1014 / 1000; dv = w;
    end else if (h < era_start[3]) begin
      lo = w * 1000 / 1028; hi = w * 1028 / 1000; dv = w;
    end else if (h < era_start[4]) begin
      lo = 59; hi = 61; dv = 60;
    end else begin
      lo = 37; hi = 39; dv = 38;
    end
    if (ts < lo) ts = lo;
    if (ts > hi) ts = hi;
    prod = 288'(expand_compact(bits)) * 288'(ts[31:0]);
    if (dv == 0) val = '1;
    else val = 256'(prod[255:0] / 256'(dv));
    lim = expand_compact(limit_bits);
    if (val > lim) val = lim;
    return pack_compact(val);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) era_start[i] <= '0;
      legacy_span <= 24'd1209600;
      window_span <= 24'd60;
      limit_bits  <= 32'h1d00ffff;
      fail_count  <= 0;
      target_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ERA1, CFG_ERA2, CFG_ERA3, CFG_ERA4, CFG_ERA5: begin
            era_start[cfg_index[2:0]] <= cfg_data[30:0];
          end
          CFG_LEGACY: legacy_span <= cfg_data[23:0];
          CFG_WINDOW: window_span <= cfg_data[23:0];
          CFG_LIMIT:  limit_bits <= cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        target_q.push_back(retarget(in_mon.next_height, in_mon.last_bits,
                                    in_mon.last_time, in_mon.first_time));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (target_q.size() == 0) begin
          $display("%0t: unexpected new_bits %h", $time, out_mon.new_bits);
          fail_count <= fail_count + 1;
        end else begin
          if (target_q[0] !== out_mon.new_bits) begin
            $display("%0t: new_bits expected %h actual %h", $time, target_q[0],
                     out_mon.new_bits);
            fail_count <= fail_count + 1;
          end
          void'(target_q.pop_front());
        end
      end
    end
  end
endmodule

// ----- dv/testbench.sv -----
// Top of the difficulty retarget testbench: clock, reset, stimulus and verdict.
module testbench;
  import drt_pkg::*;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;
  int                    send_idle;
  int                    recv_idle;
  int                    hold_cycles;

  drt_in_if  in_ch ();
  drt_out_if out_ch ();

  difficulty_retarget u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  drt_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off while hold_cycles is set.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 0;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  // Valid stays high after an accepted transaction so that requests can follow
  // back to back; it drops only while the sender idles or drains.
  task automatic send_request(logic [30:0] h, logic [31:0] bits, logic [31:0] tl,
                              logic [31:0] tf);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid       <= 1;
    in_ch.next_height <= h;
    in_ch.last_bits   <= bits;
    in_ch.last_time   <= tl;
    in_ch.first_time  <= tf;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Timestamps mostly near the window's span so the clamp bounds are straddled.
  task automatic random_request();
    logic [31:0] tf, bits;
    int          span;
    tf = $urandom;
    case ($urandom_range(3))
      0: span = $urandom_range(120) - 20;
      1: span = $urandom_range(1300) - 100;
      2: span = $urandom_range(5000000);
      default: span = $urandom;
    endcase
    bits = $urandom_range(3) == 0 ? $urandom
         : {8'($urandom_range(34)), 1'($urandom), 23'($urandom)};
    send_request(31'($urandom_range(2000)) | ($urandom_range(9) == 0 ? 31'($urandom) : 31'd0),
                 bits, tf + span, tf);
  endtask

  task automatic era_setup(int a, int b, int c, int d, int e);
    write_reg(CFG_ERA1, a);
    write_reg(CFG_ERA2, b);
    write_reg(CFG_ERA3, c);
    write_reg(CFG_ERA4, d);
    write_reg(CFG_ERA5, e);
  endtask

  initial begin
    in_ch.valid       = 0;
    in_ch.next_height = '0;
    in_ch.last_bits   = '0;
    in_ch.last_time   = '0;
    in_ch.first_time  = '0;
    send_idle   = 0;
    recv_idle   = 0;
    hold_cycles = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: every era, clamp extremes, compact edge cases, negative spans.
    era_setup(100, 200, 300, 400, 500);
    write_reg(CFG_LEGACY, 1000);
    write_reg(CFG_WINDOW, 60);
    for (int e = 0; e < 6; e++) begin
      send_request(31'(e * 100 + 50), 32'h1c0fffff, 32'd100, 32'd200);
      send_request(31'(e * 100 + 50), 32'h1b7fffff, 32'hffffffff, 32'd0);
      send_request(31'(e * 100 + 50), 32'h1a812345, 32'd1000, 32'd940);
    end
    send_request(31'h7fffffff, 32'hffffffff, 32'd0, 32'hffffffff);
    send_request(31'd0, 32'h00000000, 32'd0, 32'd0);
    send_request(31'd0, 32'h01ffffff, 32'd5, 32'd0);
    send_request(31'd0, 32'h02ffffff, 32'd5, 32'd0);
    send_request(31'd450, 32'h22123456, 32'd61, 32'd0);
    send_request(31'd450, 32'h21123456, 32'd61, 32'd0);
    send_request(31'd450, 32'h00800000, 32'd61, 32'd0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          era_setup(400, 800, 1200, 1600, 1800);
          write_reg(CFG_LIMIT, 32'h2100ffff);
        end
        1: begin
          write_reg(CFG_LEGACY, 4);
          write_reg(CFG_WINDOW, 2);
          write_reg(CFG_LIMIT, 32'hffffffff);
        end
        2: begin
          write_reg(CFG_LEGACY, 24'hffffff);
          write_reg(CFG_WINDOW, 24'hffffff);
          write_reg(CFG_LIMIT, 32'h00000000);
        end
        3: begin
          write_reg(CFG_LEGACY, 0);
          write_reg(CFG_WINDOW, 0);
          write_reg(CFG_LIMIT, 32'h1d00ffff);
        end
        4: begin
          era_setup(2147483647, 2147483647, 2147483647, 2147483647, 2147483647);
          write_reg(CFG_LEGACY, 1209600);
          write_reg(CFG_WINDOW, 600);
          write_reg(CFG_LIMIT, 32'h207fffff);
        end
        default: begin
          era_setup(0, 300, 600, 900, 1500);
          write_reg(CFG_WINDOW, 1000);
        end
      endcase
      send_idle = phase < 2 ? 34 : (phase < 4 ? 63 : 0);
      recv_idle = phase < 2 ? 63 : (phase < 4 ? 34 : 0);
      if (phase == 4) hold_cycles = 120;
      for (int n = 0; n < 280; n++) random_request();
      if (phase == 1) drain();
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
